@@ rtl/scb_pkg.sv @@
// ----------------------------------------------------------------------------
// scb_pkg - shared types, codes and lookup tables
// Scan-code decode tables and report payload type for the button report core.
// ----------------------------------------------------------------------------
package scb_pkg;

    localparam int unsigned MAP_W = 36;

    // decode kinds of a make code
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_PLAIN = 2'd1;
    localparam logic [1:0] K_HAT1  = 2'd2;
    localparam logic [1:0] K_HAT2  = 2'd3;

    localparam logic [7:0] C_BREAK_OFS = 8'd64;
    localparam logic [5:0] C_HAT1_BASE = 6'd6;
    localparam logic [5:0] C_HAT2_BASE = 6'd14;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] idx;
    } t_code_info;

    typedef struct packed {
        logic [MAP_W-1:0] button_map;
        logic             last_report;
    } t_report;

    // one set or clear of a map bit
    typedef struct packed {
        logic [5:0] idx;
        logic       val;
    } t_bit_op;

    // make code 1..32 to button index or hat
    function automatic t_code_info f_code_info(input logic [5:0] k);
        t_code_info r;
        r.kind = K_PLAIN;
        r.idx  = 6'd0;
        case (k)
            6'd1:  r.idx = 6'd4;
            6'd2:  r.idx = 6'd2;
            6'd3:  r.idx = 6'd3;
            6'd4:  r.idx = 6'd1;
            6'd5, 6'd6, 6'd7, 6'd8:     r.kind = K_HAT1;
            6'd9, 6'd10, 6'd11, 6'd12:  r.kind = K_HAT2;
            6'd13: r.idx = 6'd0;
            6'd14: r.idx = 6'd5;
            6'd15: r.idx = 6'd22;
            6'd16: r.idx = 6'd23;
            6'd17: r.idx = 6'd32;
            6'd18: r.idx = 6'd35;
            6'd19: r.idx = 6'd33;
            6'd20: r.idx = 6'd34;
            6'd21: r.idx = 6'd28;
            6'd22: r.idx = 6'd31;
            6'd23: r.idx = 6'd29;
            6'd24: r.idx = 6'd30;
            6'd29: r.idx = 6'd27;
            6'd30: r.idx = 6'd26;
            6'd31: r.idx = 6'd25;
            6'd32: r.idx = 6'd24;
            default: r.kind = K_NONE;
        endcase
        return r;
    endfunction

    // hat direction: 0 up, 1 down, 2 and 3 the horizontal pair
    function automatic logic [1:0] f_hat_dir(input logic [1:0] sel);
        logic [1:0] d;
        case (sel)
            2'd0:    d = 2'd0;
            2'd1:    d = 2'd3;
            2'd2:    d = 2'd1;
            default: d = 2'd2;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/scb_in_if.sv @@
// ----------------------------------------------------------------------------
// scb_in_if - scan code request channel
// Valid/ready channel carrying one scan code per request.
// ----------------------------------------------------------------------------
interface scb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

@@ rtl/scb_out_if.sv @@
// ----------------------------------------------------------------------------
// scb_out_if - button report channel
// Valid/ready channel carrying the full button map per request.
// ----------------------------------------------------------------------------
interface scb_out_if;
    logic        valid;
    logic        ready;
    logic [35:0] button_map;
    logic        last_report;

    modport source (output valid, output button_map, output last_report, input ready);
    modport sink   (input valid, input button_map, input last_report, output ready);
endinterface

@@ rtl/scb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// scb_cfg_if - configuration write channel
// Valid/ready channel writing the report enable register.
// ----------------------------------------------------------------------------
interface scb_cfg_if;
    logic valid;
    logic ready;
    logic report_enable;

    modport source (output valid, output report_enable, input ready);
    modport sink   (input valid, input report_enable, output ready);
endinterface

@@ rtl/scancode_to_button_report_core.sv @@
// ----------------------------------------------------------------------------
// scancode_to_button_report_core - scan code to button map reports
// Decodes controller make/break codes into a 36-bit button map with two
// diagonal-aware hats and emits up to two full-map reports per code.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                      | request moves
//  ---------+-----+------------------------------+---------------------------
//  i_in     | in  | scan_code[7:0]               | one scan code
//  o_out    | out | button_map[35:0], last_report| one full-map report
//  i_cfg    | in  | report_enable                | one register write
//
//  A code is taken into an input register, then decoded combinationally into
//  at most two bit operations which update the state and land as reports in
//  a two-entry result buffer. The input register accepts a new request while
//  reports still wait, and holds its code while the buffer lacks room. Reset
//  (i_rst_n low at a clock edge) clears the map, both hats, the enable and all
//  valids.
// ----------------------------------------------------------------------------
module scancode_to_button_report_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scb_in_if.sink     i_in,
    scb_cfg_if.sink    i_cfg,
    scb_out_if.source  o_out
);
    import scb_pkg::*;

    // state
    logic             r_enable;
    logic [MAP_W-1:0] r_buttons;
    logic [3:0]       r_hat1;
    logic [3:0]       r_hat2;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_code;

    // result buffer, entry 0 is the head
    t_report          r_res [2];
    logic [1:0]       r_cnt;

    // decode
    logic             is_make;
    logic             is_break;
    logic [5:0]       key;
    t_code_info       info;
    logic [1:0]       dir;
    logic [3:0]       dirs_cur;
    logic [3:0]       dirs_new;
    logic [5:0]       base;
    logic [1:0]       p1;
    logic [1:0]       p2;
    logic [5:0]       diag1;
    logic [5:0]       diag2;
    t_bit_op          op_a;
    t_bit_op          op_b;
    logic [1:0]       n_ops;
    logic [1:0]       n_add;
    logic [MAP_W-1:0] map_a;
    logic [MAP_W-1:0] map_b;
    logic [MAP_W-1:0] map_fin;

    // buffer control
    logic             pop;
    logic             fire;
    logic [1:0]       base_cnt;
    logic [2:0]       need_cnt;
    t_report          n_res [2];
    logic [1:0]       n_cnt;

    // ---- decode the held code into bit operations ----
    always_comb begin
        is_make  = r_code inside {[8'd1:8'd32]};
        is_break = r_code inside {[8'd65:8'd96]};
        key      = is_make ? r_code[5:0] : 6'(r_code - C_BREAK_OFS);
        info     = f_code_info(key);
        dir      = f_hat_dir(2'(key - 6'd5));

        dirs_cur = (info.kind == K_HAT1) ? r_hat1 : r_hat2;
        base     = (info.kind == K_HAT1) ? C_HAT1_BASE : C_HAT2_BASE;
        if (is_make) begin
            dirs_new = dirs_cur | (4'd1 << dir);
        end else begin
            dirs_new = dirs_cur & ~(4'd1 << dir);
        end

        // partners of a vertical press are the horizontal pair and vice versa
        if (!dir[1]) begin
            p1    = 2'd2;
            p2    = 2'd3;
            diag1 = base + 6'd4 + {4'd0, dir[0], 1'b0};
            diag2 = base + 6'd5 + {4'd0, dir[0], 1'b0};
        end else begin
            p1    = 2'd0;
            p2    = 2'd1;
            diag1 = base + 6'd4 + {5'd0, dir[0]};
            diag2 = base + 6'd6 + {5'd0, dir[0]};
        end

        op_a  = '{idx: 6'd0, val: 1'b0};
        op_b  = '{idx: 6'd0, val: 1'b0};
        n_ops = 2'd0;
        if (is_make || is_break) begin
            case (info.kind)
                K_PLAIN: begin
                    op_a  = '{idx: info.idx, val: is_make};
                    n_ops = 2'd1;
                end
                K_HAT1, K_HAT2: begin
                    // first partner held decides the diagonal
                    if (dirs_new[p1]) begin
                        op_a  = '{idx: is_make ? base + {4'd0, p1} : diag1, val: 1'b0};
                        op_b  = '{idx: is_make ? diag1 : base + {4'd0, p1}, val: 1'b1};
                        n_ops = 2'd2;
                    end else if (dirs_new[p2]) begin
                        op_a  = '{idx: is_make ? base + {4'd0, p2} : diag2, val: 1'b0};
                        op_b  = '{idx: is_make ? diag2 : base + {4'd0, p2}, val: 1'b1};
                        n_ops = 2'd2;
                    end else begin
                        op_a  = '{idx: base + {4'd0, dir}, val: is_make};
                        n_ops = 2'd1;
                    end
                end
                default: n_ops = 2'd0;
            endcase
        end

        // apply the operations in order
        if (op_a.val) begin
            map_a = r_buttons | (MAP_W'(1) << op_a.idx);
        end else begin
            map_a = r_buttons & ~(MAP_W'(1) << op_a.idx);
        end
        if (op_b.val) begin
            map_b = map_a | (MAP_W'(1) << op_b.idx);
        end else begin
            map_b = map_a & ~(MAP_W'(1) << op_b.idx);
        end
        case (n_ops)
            2'd1:    map_fin = map_a;
            2'd2:    map_fin = map_b;
            default: map_fin = r_buttons;
        endcase
        n_add = r_enable ? n_ops : 2'd0;
    end

    // ---- handshakes ----
    assign pop      = o_out.valid && o_out.ready;
    assign base_cnt = r_cnt - {1'b0, pop};
    assign need_cnt = {1'b0, base_cnt} + {1'b0, n_add};
    // fire only when the buffer has room for every report of this code
    assign fire     = r_in_valid && (need_cnt <= 3'd2);

    assign i_in.ready       = !r_in_valid || fire;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.button_map = r_res[0].button_map;
    assign o_out.last_report = r_res[0].last_report;

    // ---- result buffer next value: advance on pop, append on fire ----
    always_comb begin
        n_res = r_res;
        if (pop) begin
            n_res[0] = r_res[1];
        end
        n_cnt = base_cnt;
        if (fire) begin
            case (n_add)
                2'd1: begin
                    n_res[base_cnt[0]] = '{button_map: map_a, last_report: 1'b1};
                end
                2'd2: begin
                    n_res[0] = '{button_map: map_a, last_report: 1'b0};
                    n_res[1] = '{button_map: map_b, last_report: 1'b1};
                end
                default: n_res = n_res;
            endcase
            n_cnt = need_cnt[1:0];
        end
    end

    // ---- control and state registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_buttons  <= '0;
            r_hat1     <= '0;
            r_hat2     <= '0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_enable <= i_cfg.report_enable;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_buttons <= map_fin;
                if ((is_make || is_break) && info.kind == K_HAT1) begin
                    r_hat1 <= dirs_new;
                end
                if ((is_make || is_break) && info.kind == K_HAT2) begin
                    r_hat2 <= dirs_new;
                end
            end
            r_cnt <= n_cnt;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_code <= i_in.scan_code;
        end
        r_res <= n_res;
    end

    // ---- assertions ----
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_code)))
        else $error("held scan code lost while buffer full");

    a_disabled_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_enable) |=> (r_cnt == $past(r_cnt) - {1'b0, $past(pop)}))
        else $error("report queued while reporting disabled");

endmodule
